// ----- hw/rtl/saa_pkg.sv -----
// Shared types and codes for the skyline atlas allocator.
package saa_pkg;

  // Field widths of the item and result beats
  localparam int RECT_W  = 8;
  localparam int PAGE_W  = 6;
  localparam int POS_W   = 7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_A_INIT,
    OP_NEXT_PAGE,
    OP_A_RUN,
    OP_B_INIT,
    OP_B_RUN,
    OP_MARK_FULL,
    OP_FILL_INIT,
    OP_FILL,
    OP_RESULT
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR,
    ST_A_RUN,
    ST_B_INIT,
    ST_B_RUN,
    ST_DECIDE,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic is_clear;
    logic len_ok;
    logic clear_last;
    logic a_done;
    logic b_done;
    logic fits;
    logic page_last;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/saa_ctrl.sv -----
// Sequencer for clear sweeps, per-page skyline scans and column fills.
module saa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  saa_pkg::sts_t  sts,
  output saa_pkg::ctl_t  ctl
);

  saa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= saa_pkg::ST_INIT_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      saa_pkg::ST_INIT_CLEAR: begin
        if (sts.clear_last) state_next = saa_pkg::ST_IDLE;
      end
      saa_pkg::ST_IDLE: begin
        if (in_valid) state_next = saa_pkg::ST_DISPATCH;
      end
      saa_pkg::ST_DISPATCH: begin
        if (sts.is_clear) state_next = saa_pkg::ST_CLEAR;
        else if (!sts.len_ok) state_next = saa_pkg::ST_DONE;
        else state_next = saa_pkg::ST_A_RUN;
      end
      saa_pkg::ST_CLEAR: begin
        if (sts.clear_last) state_next = saa_pkg::ST_DONE;
      end
      saa_pkg::ST_A_RUN: begin
        if (sts.a_done) state_next = saa_pkg::ST_B_INIT;
      end
      saa_pkg::ST_B_INIT: begin
        state_next = saa_pkg::ST_B_RUN;
      end
      saa_pkg::ST_B_RUN: begin
        if (sts.b_done) state_next = saa_pkg::ST_DECIDE;
      end
      saa_pkg::ST_DECIDE: begin
        if (sts.fits) state_next = saa_pkg::ST_FILL;
        else if (sts.page_last) state_next = saa_pkg::ST_DONE;
        else state_next = saa_pkg::ST_A_RUN;
      end
      saa_pkg::ST_FILL: begin
        if (sts.fill_last) state_next = saa_pkg::ST_DONE;
      end
      saa_pkg::ST_DONE: begin
        if (sts.out_free) state_next = saa_pkg::ST_IDLE;
      end
      default: state_next = saa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    ctl.op   = saa_pkg::OP_NONE;
    case (state)
      saa_pkg::ST_INIT_CLEAR: ctl.op = saa_pkg::OP_CLEAR;
      saa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) ctl.op = saa_pkg::OP_LOAD;
      end
      saa_pkg::ST_DISPATCH: begin
        if (sts.is_clear) ctl.op = saa_pkg::OP_NONE;
        else if (!sts.len_ok) ctl.op = saa_pkg::OP_MARK_FULL;
        else ctl.op = saa_pkg::OP_A_INIT;
      end
      saa_pkg::ST_CLEAR:  ctl.op = saa_pkg::OP_CLEAR;
      saa_pkg::ST_A_RUN:  ctl.op = saa_pkg::OP_A_RUN;
      saa_pkg::ST_B_INIT: ctl.op = saa_pkg::OP_B_INIT;
      saa_pkg::ST_B_RUN:  ctl.op = saa_pkg::OP_B_RUN;
      saa_pkg::ST_DECIDE: begin
        if (sts.fits) ctl.op = saa_pkg::OP_FILL_INIT;
        else if (sts.page_last) ctl.op = saa_pkg::OP_MARK_FULL;
        else ctl.op = saa_pkg::OP_NEXT_PAGE;
      end
      saa_pkg::ST_FILL: ctl.op = saa_pkg::OP_FILL;
      saa_pkg::ST_DONE: begin
        if (sts.out_free) ctl.op = saa_pkg::OP_RESULT;
      end
      default: ctl.op = saa_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/saa_dp.sv -----
// Height store, block-max scan buffer, best-start tracking and result register.
module saa_dp #(
  parameter int PAGES   = 64,
  parameter int COLUMNS = 128,
  parameter int ROWS    = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd,
  input  logic [saa_pkg::RECT_W-1:0]     rect_width,
  input  logic [saa_pkg::RECT_W-1:0]     rect_height,
  input  saa_pkg::ctl_t                  ctl,
  output saa_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           status,
  output logic [saa_pkg::PAGE_W-1:0]     page,
  output logic [saa_pkg::POS_W-1:0]      pos_x,
  output logic [saa_pkg::POS_W-1:0]      pos_y
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int TOTAL = PAGES * COLUMNS;
  localparam int AW    = $clog2(TOTAL);
  localparam int HW    = $clog2(ROWS + 1);
  localparam int SW    = ((HW > saa_pkg::RECT_W) ? HW : saa_pkg::RECT_W) + 1;
  localparam int XPW   = PGW + saa_pkg::PAGE_W;
  localparam int XXW   = CW + saa_pkg::POS_W;
  localparam int XYW   = HW + saa_pkg::POS_W;

  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [CW-1:0] PEN_COL  = CW'(COLUMNS - 2);

  logic [HW-1:0] heights [TOTAL];
  logic [HW-1:0] blkbuf  [COLUMNS];

  logic                       is_clear;
  logic [saa_pkg::RECT_W-1:0] wid_raw;
  logic [saa_pkg::RECT_W-1:0] hgt;
  logic [CW-1:0]              wm1;
  logic                       res_full;
  logic [PGW-1:0]             page_idx;
  logic [AW-1:0]              base;
  logic [AW-1:0]              clr;
  logic [CW-1:0]              pos;
  logic                       iss_live;
  logic                       p1_vld;
  logic [CW-1:0]              p1_pos;
  logic [CW-1:0]              blk;
  logic [HW-1:0]              run_max;
  logic [HW-1:0]              best;
  logic [CW-1:0]              best_x;
  logic                       found;
  logic [CW-1:0]              cnt;
  logic [HW-1:0]              fillv;
  logic [HW-1:0]              hrd;
  logic [HW-1:0]              brd;

  logic [AW-1:0]  h_addr;
  logic           h_wen;
  logic [HW-1:0]  h_wdata;
  logic [CW-1:0]  b_raddr;
  logic           b_wen;
  logic [CW-1:0]  c_a;
  logic [HW-1:0]  s_a;
  logic [CW-1:0]  c_b;
  logic [HW-1:0]  p_b;
  logic [HW-1:0]  top_b;
  logic [SW-1:0]  sum;
  logic [XPW-1:0] pg_ext;
  logic [XXW-1:0] x_ext;
  logic [XYW-1:0] y_ext;

  // Pass A runs right to left: suffix max inside blocks of width anchored at the right edge.
  // Pass B runs left to right: prefix max inside the same blocks, joined with the buffered
  // suffix max at the window start.
  always_comb begin
    c_a   = (p1_pos == LAST_COL || blk == wm1) ? '0 : blk + 1'b1;
    s_a   = (c_a == '0 || hrd > run_max) ? hrd : run_max;
    c_b   = (p1_pos == '0) ? blk : ((blk == '0) ? wm1 : blk - 1'b1);
    p_b   = (c_b == wm1 || p1_pos == '0 || hrd > run_max) ? hrd : run_max;
    top_b = (brd > p_b) ? brd : p_b;
    sum   = SW'(best) + SW'(hgt);
  end

  assign pg_ext = XPW'(page_idx);
  assign x_ext  = XXW'(best_x);
  assign y_ext  = XYW'(best);

  always_comb begin
    h_addr  = base + AW'(pos);
    h_wen   = 1'b0;
    h_wdata = fillv;
    if (ctl.op == saa_pkg::OP_CLEAR) begin
      h_addr  = clr;
      h_wen   = 1'b1;
      h_wdata = '0;
    end else if (ctl.op == saa_pkg::OP_FILL) begin
      h_wen = 1'b1;
    end
  end

  assign b_raddr = pos - wm1;
  assign b_wen   = (ctl.op == saa_pkg::OP_A_RUN) && p1_vld;

  always_ff @(posedge clk) begin
    if (h_wen) heights[h_addr] <= h_wdata;
    hrd <= heights[h_addr];
  end

  always_ff @(posedge clk) begin
    if (b_wen) blkbuf[p1_pos] <= s_a;
    brd <= blkbuf[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      iss_live  <= 1'b0;
      p1_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_vld <= 1'b0;
      case (ctl.op)
        saa_pkg::OP_CLEAR: begin
          clr <= sts.clear_last ? '0 : clr + 1'b1;
        end
        saa_pkg::OP_A_INIT, saa_pkg::OP_NEXT_PAGE, saa_pkg::OP_B_INIT: begin
          iss_live <= 1'b1;
        end
        saa_pkg::OP_A_RUN: begin
          p1_vld <= iss_live;
          if (iss_live && pos == '0) iss_live <= 1'b0;
        end
        saa_pkg::OP_B_RUN: begin
          p1_vld <= iss_live;
          if (iss_live && pos == PEN_COL) iss_live <= 1'b0;
        end
        default: ;
      endcase
      if (ctl.op == saa_pkg::OP_RESULT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      saa_pkg::OP_LOAD: begin
        is_clear <= cmd;
        wid_raw  <= rect_width;
        wm1      <= CW'(rect_width - 8'd1);
        hgt      <= rect_height;
        res_full <= 1'b0;
        page_idx <= '0;
        base     <= '0;
      end
      saa_pkg::OP_A_INIT: begin
        pos <= LAST_COL;
      end
      saa_pkg::OP_NEXT_PAGE: begin
        pos      <= LAST_COL;
        page_idx <= page_idx + 1'b1;
        base     <= base + AW'(COLUMNS);
      end
      saa_pkg::OP_A_RUN: begin
        pos    <= pos - 1'b1;
        p1_pos <= pos;
        if (p1_vld) begin
          blk     <= c_a;
          run_max <= s_a;
        end
      end
      saa_pkg::OP_B_INIT: begin
        pos   <= '0;
        best  <= HW'(ROWS);
        found <= 1'b0;
      end
      saa_pkg::OP_B_RUN: begin
        pos    <= pos + 1'b1;
        p1_pos <= pos;
        if (p1_vld) begin
          blk     <= c_b;
          run_max <= p_b;
          // keep the leftmost start on ties
          if (p1_pos >= wm1 && top_b < best) begin
            best   <= top_b;
            best_x <= p1_pos - wm1;
            found  <= 1'b1;
          end
        end
      end
      saa_pkg::OP_MARK_FULL: begin
        res_full <= 1'b1;
      end
      saa_pkg::OP_FILL_INIT: begin
        pos   <= best_x;
        cnt   <= wm1;
        fillv <= HW'(sum);
      end
      saa_pkg::OP_FILL: begin
        pos <= pos + 1'b1;
        cnt <= cnt - 1'b1;
      end
      saa_pkg::OP_RESULT: begin
        status <= res_full;
        if (res_full || is_clear) begin
          page  <= '0;
          pos_x <= '0;
          pos_y <= '0;
        end else begin
          page  <= pg_ext[saa_pkg::PAGE_W-1:0];
          pos_x <= x_ext[saa_pkg::POS_W-1:0];
          pos_y <= y_ext[saa_pkg::POS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.is_clear   = is_clear;
    sts.len_ok     = (wid_raw != '0) && (32'(wid_raw) < 32'(COLUMNS));
    sts.clear_last = (clr == AW'(TOTAL - 1));
    sts.a_done     = p1_vld && (p1_pos == '0);
    sts.b_done     = p1_vld && (p1_pos == PEN_COL);
    sts.fits       = found && (sum <= SW'(ROWS));
    sts.page_last  = (page_idx == PGW'(PAGES - 1));
    sts.fill_last  = (cnt == '0);
    sts.out_free   = !out_valid || !out_stall;
  end

endmodule

// ----- hw/rtl/skyline_atlas_allocator_unit.sv -----
// Allocate: A and B scans per page tried, then a rect_width column fill, set by one height port.
// Full or bad width: scan of every page, or no scan when the width has no start column.
// Clear: all PAGES*COLUMNS height entries written, one height entry per cycle.
// One item at a time; the next is taken while the last result beat still waits.
// Reset runs a clearing sweep over all PAGES*COLUMNS entries with in_stall high.
module skyline_atlas_allocator_unit #(
  parameter int PAGES   = 64,
  parameter int COLUMNS = 128,
  parameter int ROWS    = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [saa_pkg::RECT_W-1:0]  rect_width,
  input  logic [saa_pkg::RECT_W-1:0]  rect_height,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        status,
  output logic [saa_pkg::PAGE_W-1:0]  page,
  output logic [saa_pkg::POS_W-1:0]   pos_x,
  output logic [saa_pkg::POS_W-1:0]   pos_y
);

  saa_pkg::ctl_t ctl;
  saa_pkg::sts_t sts;

  saa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  saa_dp #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .ctl         (ctl),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .page        (page),
    .pos_x       (pos_x),
    .pos_y       (pos_y)
  );

endmodule
